>>> hdl/uvct_pkg.sv
// Shared types and constants for the UV exposure countdown timer.
package uvct_pkg;

  localparam int ADC_BITS_DEF = 10;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK   = 2'd0;
  localparam req_t REQ_KEY    = 2'd1;
  localparam req_t REQ_SAMPLE = 2'd2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SET_MIN = 2'd1;
  localparam mode_t MODE_SET_SEC = 2'd2;
  localparam mode_t MODE_COUNT   = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TICKS_PER_SEC = 2'd0;
  localparam cfg_idx_t CFG_PRESS_THRESH  = 2'd1;

  localparam logic [7:0] TICKS_PER_SEC_RST = 8'd64;
  localparam logic [7:0] PRESS_THRESH_RST  = 8'd150;
  localparam logic [7:0] LIVE_PARKED       = 8'd200;
  localparam logic [5:0] SEC_RELOAD        = 6'd59;
  localparam logic [7:0] FIELD6_MAX        = 8'd63;
  localparam logic [7:0] SCALED_MAX        = 8'd255;

  // floor(adc*36/625) == (adc*SCALE_MUL) >> SCALE_SHIFT for adc < 74898
  localparam int              SCALE_MUL_W = 20;
  localparam int              SCALE_SHIFT = 24;
  localparam logic [19:0]     SCALE_MUL   = 20'd966368;

  typedef struct packed {
    req_t       req;
    logic [7:0] scaled;
  } item_t;

endpackage

>>> hdl/uvct_in_stage.sv
// Input register: captures a transfer and the scaled potentiometer value.
module uvct_in_stage #(
  parameter int ADC_BITS = uvct_pkg::ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  uvct_pkg::req_t       in_req_type,
  input  logic [ADC_BITS-1:0]  in_adc_value,
  output logic                 item_valid,
  output uvct_pkg::item_t      item
);
  import uvct_pkg::*;

  localparam int PW = ADC_BITS + SCALE_MUL_W;

  logic [PW-1:0] prod;
  logic [PW-1:0] quot;
  logic [7:0]    scaled;
  logic          valid_r;
  item_t         item_r;

  assign prod   = PW'(in_adc_value) * PW'(SCALE_MUL);
  assign quot   = prod >> SCALE_SHIFT;
  assign scaled = (quot > PW'(SCALED_MAX)) ? SCALED_MAX : quot[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.req    <= in_req_type;
      item_r.scaled <= scaled;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hdl/uvct_core.sv
// Timer state, configuration registers and result register.
module uvct_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  uvct_pkg::cfg_idx_t                  cfg_index,
  input  logic [uvct_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  input  uvct_pkg::item_t                     item,
  output logic                                item_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output uvct_pkg::mode_t                     out_mode,
  output logic [5:0]                          out_minutes_left,
  output logic [5:0]                          out_seconds_left,
  output logic [7:0]                          out_live_value,
  output logic                                out_lamp_on
);
  import uvct_pkg::*;

  logic [7:0] tps_r, thr_r;
  mode_t      mode_r, mode_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [7:0] live_r, live_nxt;
  logic [7:0] pre_r, pre_nxt;
  logic       lamp_r, lamp_nxt;
  logic       out_valid_r;
  logic       adv;
  logic [7:0] pre_inc;
  logic [5:0] live_sat;

  assign adv        = item_valid && (!out_valid_r || !out_stall);
  assign item_stall = item_valid && !adv;
  assign pre_inc    = pre_r + 8'd1;
  assign live_sat   = (live_r > FIELD6_MAX) ? FIELD6_MAX[5:0] : live_r[5:0];

  always_comb begin
    mode_nxt = mode_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    live_nxt = live_r;
    pre_nxt  = pre_r;
    lamp_nxt = lamp_r;
    unique case (item.req)
      REQ_TICK: begin
        pre_nxt = pre_inc;
        if (pre_inc == tps_r) begin
          pre_nxt = 8'd0;
          if (mode_r == MODE_COUNT) begin
            if (sec_r != 6'd0) begin
              sec_nxt = sec_r - 6'd1;
            end else if (min_r != 6'd0) begin
              min_nxt = min_r - 6'd1;
              sec_nxt = SEC_RELOAD;
            end else begin
              mode_nxt = MODE_SET_MIN;
              lamp_nxt = 1'b0;
            end
          end
        end
      end
      REQ_KEY: begin
        if (live_r < thr_r) begin
          unique case (mode_r)
            MODE_SET_MIN: begin
              min_nxt  = live_sat;
              live_nxt = LIVE_PARKED;
              mode_nxt = MODE_SET_SEC;
            end
            MODE_SET_SEC: begin
              sec_nxt  = live_sat;
              live_nxt = LIVE_PARKED;
              lamp_nxt = 1'b1;
              mode_nxt = MODE_COUNT;
            end
            MODE_COUNT: begin
              live_nxt = LIVE_PARKED;
              lamp_nxt = 1'b0;
              mode_nxt = MODE_SET_MIN;
            end
            default: ;
          endcase
        end
      end
      REQ_SAMPLE: begin
        if (mode_r == MODE_SET_MIN || mode_r == MODE_SET_SEC) begin
          live_nxt = item.scaled;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TICKS_PER_SEC_RST;
      thr_r <= PRESS_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_SEC: tps_r <= cfg_data;
        CFG_PRESS_THRESH:  thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state doubles as the result payload: it only moves when the result slot frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SET_MIN;
      min_r       <= 6'd0;
      sec_r       <= 6'd0;
      live_r      <= LIVE_PARKED;
      pre_r       <= 8'd0;
      lamp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        mode_r <= mode_nxt;
        min_r  <= min_nxt;
        sec_r  <= sec_nxt;
        live_r <= live_nxt;
        pre_r  <= pre_nxt;
        lamp_r <= lamp_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mode         = mode_r;
  assign out_minutes_left = min_r;
  assign out_seconds_left = sec_r;
  assign out_live_value   = live_r;
  assign out_lamp_on      = lamp_r;

endmodule

>>> hdl/uv_exposure_countdown_timer.sv
// Top level of the UV exposure countdown timer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  req_type, adc_value
//   out_     output     out_valid/out_stall mode, minutes_left, seconds_left,
//                                          live_value, lamp_on
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// One transfer per cycle while in_stall is low; a result is valid once its
// transfer has passed the input register, then the state/result register.
// Reset is synchronous: mode 1, counts zero, live value 200, lamp off,
// 64 ticks per second, threshold 150.
// out_stall holds the result and the state; the input register keeps
// taking transfers until it holds one that cannot advance.
module uv_exposure_countdown_timer #(
  parameter int ADC_BITS = uvct_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  uvct_pkg::req_t                   in_req_type,
  input  logic [ADC_BITS-1:0]              in_adc_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output uvct_pkg::mode_t                  out_mode,
  output logic [5:0]                       out_minutes_left,
  output logic [5:0]                       out_seconds_left,
  output logic [7:0]                       out_live_value,
  output logic                             out_lamp_on,
  input  logic                             cfg_we,
  input  uvct_pkg::cfg_idx_t               cfg_index,
  input  logic [uvct_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import uvct_pkg::*;

  logic  item_valid;
  logic  item_stall;
  item_t item;

  assign in_stall = item_stall;

  uvct_in_stage #(
    .ADC_BITS(ADC_BITS)
  ) u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (item_stall),
    .in_req_type (in_req_type),
    .in_adc_value(in_adc_value),
    .item_valid  (item_valid),
    .item        (item)
  );

  uvct_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item            (item),
    .item_stall      (item_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mode        (out_mode),
    .out_minutes_left(out_minutes_left),
    .out_seconds_left(out_seconds_left),
    .out_live_value  (out_live_value),
    .out_lamp_on     (out_lamp_on)
  );

endmodule

>>> tb/uv_exposure_countdown_timer_tb.sv
// Self-checking testbench for the UV exposure countdown timer: directed table, then random phases.
module uv_exposure_countdown_timer_tb;
  import uvct_pkg::*;

  localparam req_t REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    mode_t      mode;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] live;
    logic       lamp;
  } status_t;

  typedef struct packed {
    logic       is_cfg;
    cfg_idx_t   idx;
    logic [7:0] data;
    req_t       req;
    logic [9:0] adc;
    logic       typed;
    status_t    want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  req_t       in_req_type;
  logic [9:0] in_adc_value;
  logic       out_valid;
  logic       out_stall;
  mode_t      out_mode;
  logic [5:0] out_minutes_left;
  logic [5:0] out_seconds_left;
  logic [7:0] out_live_value;
  logic       out_lamp_on;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_data;

  // timer predictor state
  mode_t      tm_mode;
  logic [5:0] tm_minutes;
  logic [5:0] tm_seconds;
  logic [7:0] tm_live;
  logic [7:0] tm_prescale;
  logic       tm_lamp;
  logic [7:0] tm_tps;
  logic [7:0] tm_thresh;

  status_t  status_q[$];
  dir_row_t dir_rows[$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  countdowns_expired = 0;
  int  presses_taken = 0;
  int  items_acted = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;

  uv_exposure_countdown_timer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_adc_value     (in_adc_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_minutes_left (out_minutes_left),
    .out_seconds_left (out_seconds_left),
    .out_live_value   (out_live_value),
    .out_lamp_on      (out_lamp_on),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  function automatic logic [5:0] clamp6(input logic [7:0] v);
    return (v > FIELD6_MAX) ? 6'd63 : v[5:0];
  endfunction

  task automatic reset_timer();
    tm_mode = MODE_SET_MIN;
    tm_minutes = '0;
    tm_seconds = '0;
    tm_live = LIVE_PARKED;
    tm_prescale = '0;
    tm_lamp = 1'b0;
    tm_tps = TICKS_PER_SEC_RST;
    tm_thresh = PRESS_THRESH_RST;
  endtask

  task automatic step_timer(input req_t req, input logic [9:0] adc, output status_t st);
    int scaled;
    case (req)
      REQ_TICK: begin
        tm_prescale = tm_prescale + 8'd1;
        if (tm_prescale == tm_tps) begin
          tm_prescale = '0;
          if (tm_mode == MODE_COUNT) begin
            if (tm_seconds != 0) begin
              tm_seconds = tm_seconds - 6'd1;
            end else if (tm_minutes != 0) begin
              tm_minutes = tm_minutes - 6'd1;
              tm_seconds = SEC_RELOAD;
            end else begin
              tm_mode = MODE_SET_MIN;
              tm_lamp = 1'b0;
              countdowns_expired++;
            end
          end
        end
      end
      REQ_KEY: begin
        if (tm_live < tm_thresh) begin
          case (tm_mode)
            MODE_SET_MIN: begin
              tm_minutes = clamp6(tm_live);
              tm_live = LIVE_PARKED;
              tm_mode = MODE_SET_SEC;
              presses_taken++;
            end
            MODE_SET_SEC: begin
              tm_seconds = clamp6(tm_live);
              tm_live = LIVE_PARKED;
              tm_lamp = 1'b1;
              tm_mode = MODE_COUNT;
              presses_taken++;
            end
            MODE_COUNT: begin
              tm_live = LIVE_PARKED;
              tm_lamp = 1'b0;
              tm_mode = MODE_SET_MIN;
              presses_taken++;
            end
            default: ;
          endcase
        end
      end
      REQ_SAMPLE: begin
        if (tm_mode == MODE_SET_MIN || tm_mode == MODE_SET_SEC) begin
          scaled = (int'(adc) * 36) / 625;
          tm_live = (scaled > 255) ? SCALED_MAX : scaled[7:0];
        end
      end
      default: ;
    endcase
    st.mode = tm_mode;
    st.minutes = tm_minutes;
    st.seconds = tm_seconds;
    st.live = tm_live;
    st.lamp = tm_lamp;
  endtask

  task automatic send_item(input req_t req, input logic [9:0] adc, input logic typed,
                           input status_t want);
    int gap;
    status_t st;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_adc_value <= adc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_timer(req, adc, st);
    status_q.push_back(typed ? want : st);
    if (req != REQ_UNUSED) items_acted++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICKS_PER_SEC: tm_tps = data;
      CFG_PRESS_THRESH: tm_thresh = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic dir_item(input req_t req, input logic [9:0] adc);
    dir_row_t r;
    r = '0;
    r.req = req;
    r.adc = adc;
    dir_rows.push_back(r);
  endtask

  task automatic dir_typed(input req_t req, input logic [9:0] adc, input mode_t m,
                           input int mins, input int secs, input int live, input bit lamp);
    dir_row_t r;
    r = '0;
    r.req = req;
    r.adc = adc;
    r.typed = 1'b1;
    r.want.mode = m;
    r.want.minutes = mins[5:0];
    r.want.seconds = secs[5:0];
    r.want.live = live[7:0];
    r.want.lamp = lamp;
    dir_rows.push_back(r);
  endtask

  task automatic dir_cfg(input cfg_idx_t idx, input logic [7:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    dir_rows.push_back(r);
  endtask

  task automatic check_status();
    status_t want;
    if (status_q.size() == 0) begin
      $error("unexpected transfer: mode %0d minutes %0d seconds %0d", out_mode,
             out_minutes_left, out_seconds_left);
      mismatch_count++;
    end else begin
      want = status_q.pop_front();
      results_checked++;
      if (out_mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, out_mode);
        mismatch_count++;
      end
      if (out_minutes_left !== want.minutes) begin
        $error("minutes_left: expected %0d, got %0d", want.minutes, out_minutes_left);
        mismatch_count++;
      end
      if (out_seconds_left !== want.seconds) begin
        $error("seconds_left: expected %0d, got %0d", want.seconds, out_seconds_left);
        mismatch_count++;
      end
      if (out_live_value !== want.live) begin
        $error("live_value: expected %0d, got %0d", want.live, out_live_value);
        mismatch_count++;
      end
      if (out_lamp_on !== want.lamp) begin
        $error("lamp_on: expected %0d, got %0d", want.lamp, out_lamp_on);
        mismatch_count++;
      end
    end
  endtask

  // result side
  initial begin
    int w;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_status();
        w = draw_wait();
        if (hold_request) begin
          hold_request = 1'b0;
          w = LONG_HOLD;
        end
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // stimulus side
  initial begin
    logic [7:0] tps;
    logic [7:0] thr;
    int goal;
    int nt;
    req_t rq;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_TICK;
    in_adc_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TICKS_PER_SEC;
    cfg_data <= '0;
    reset_timer();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_typed(REQ_KEY, 10'd0, MODE_SET_MIN, 0, 0, 200, 0);
    dir_typed(REQ_SAMPLE, 10'd0, MODE_SET_MIN, 0, 0, 0, 0);
    dir_typed(REQ_SAMPLE, 10'd1023, MODE_SET_MIN, 0, 0, 58, 0);
    dir_typed(REQ_KEY, 10'd1023, MODE_SET_SEC, 58, 0, 200, 0);
    dir_typed(REQ_SAMPLE, 10'd1023, MODE_SET_SEC, 58, 0, 58, 0);
    dir_typed(REQ_UNUSED, 10'd1023, MODE_SET_SEC, 58, 0, 58, 0);
    dir_typed(REQ_KEY, 10'd0, MODE_COUNT, 58, 58, 200, 1);
    dir_typed(REQ_SAMPLE, 10'd0, MODE_COUNT, 58, 58, 200, 1);
    dir_typed(REQ_KEY, 10'd0, MODE_COUNT, 58, 58, 200, 1);
    dir_cfg(CFG_TICKS_PER_SEC, 8'd1);
    dir_cfg(CFG_PRESS_THRESH, 8'd255);
    dir_item(REQ_TICK, 10'd0);
    dir_item(REQ_KEY, 10'd0);       // cancel from countdown
    dir_item(REQ_KEY, 10'd0);       // parked value latched, clamps to 63
    dir_item(REQ_SAMPLE, 10'd18);
    dir_item(REQ_KEY, 10'd0);
    dir_item(REQ_TICK, 10'd0);
    dir_item(REQ_TICK, 10'd0);      // borrow from minutes
    dir_item(REQ_KEY, 10'd0);
    dir_item(REQ_SAMPLE, 10'd0);
    dir_item(REQ_KEY, 10'd0);
    dir_item(REQ_SAMPLE, 10'd10);
    dir_item(REQ_KEY, 10'd0);
    dir_item(REQ_TICK, 10'd1023);   // run out, lamp off
    dir_item(REQ_UNUSED, 10'd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].req, dir_rows[i].adc, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin tps = 8'd1;   thr = 8'd255; idle_on = 1'b1; end
        1: begin tps = 8'd0;   thr = 8'd150; idle_on = 1'b1; end
        2: begin tps = 8'd255; thr = 8'd0;   idle_on = 1'b0; end
        3: begin tps = 8'd3;   thr = 8'd200; idle_on = 1'b1; end
        4: begin tps = 8'd2;   thr = 8'd6;   idle_on = 1'b1; end
        default: begin tps = 8'd1; thr = 8'd255; idle_on = 1'b1; end
      endcase
      settle();
      write_reg(CFG_TICKS_PER_SEC, tps);
      write_reg(CFG_PRESS_THRESH, thr);
      if (p == 3) hold_request = 1'b1;
      goal = items_acted + PHASE_ITEMS;
      while (items_acted < goal) begin
        if ($urandom_range(0, 9) < 4) begin
          // set minutes and seconds from small samples, then let it count
          send_item(REQ_SAMPLE, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 17))
                                                             : 10'($urandom_range(0, 120)),
                    1'b0, '0);
          send_item(REQ_KEY, 10'($urandom_range(0, 1023)), 1'b0, '0);
          send_item(REQ_SAMPLE, 10'($urandom_range(0, 120)), 1'b0, '0);
          send_item(REQ_KEY, 10'($urandom_range(0, 1023)), 1'b0, '0);
          nt = $urandom_range(1, 60);
          repeat (nt) send_item(REQ_TICK, 10'($urandom_range(0, 1023)), 1'b0, '0);
        end else begin
          rq = req_t'($urandom_range(0, 3));
          send_item(rq, 10'($urandom_range(0, 1023)), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("tb: %0d results checked over %0d configurations", results_checked,
             NUM_PHASES + 1);
    $display("tb: %0d key presses acted, %0d countdowns ran out", presses_taken,
             countdowns_expired);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/uvct_pkg.sv
hdl/uvct_in_stage.sv
hdl/uvct_core.sv
hdl/uv_exposure_countdown_timer.sv
tb/uv_exposure_countdown_timer_tb.sv
